>>> hdl/dvsm_pkg.sv
package dvsm_pkg;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    localparam logic        REQ_LOAD = 1'b0;
    localparam logic        REQ_TICK = 1'b1;
    localparam logic [15:0] MIDPOINT = 16'h8000;

    typedef struct packed {
        logic valid;
        logic last;
    } step_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic play;
    } play_t;

endpackage

>>> hdl/dvsm_sample_store.sv
module dvsm_sample_store #(
    parameter int VOICE_COUNT  = 8,
    parameter int SAMPLE_DEPTH = 32768,
    localparam int VW          = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1,
    localparam int PW          = $clog2(SAMPLE_DEPTH)
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [VW+PW-1:0]                    wr_addr,
    input  logic [15:0]                         wr_data,
    input  logic                                rd_en,
    input  logic [VW+PW-1:0]                    rd_addr,
    output logic [15:0]                         rd_data
);

    localparam int MEM_DEPTH = 1 << (VW + PW);

    logic [15:0] mem [0:MEM_DEPTH-1];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/dvsm_voice_state.sv
module dvsm_voice_state #(
    parameter int VOICE_COUNT  = 8,
    parameter int SAMPLE_DEPTH = 32768,
    localparam int VW          = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1,
    localparam int PW          = $clog2(SAMPLE_DEPTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dvsm_pkg::step_t        step_in,
    input  logic [VW-1:0]          step_voice,
    input  logic [VOICE_COUNT-1:0] trig_vec,
    output dvsm_pkg::play_t        play_out,
    output logic [VW-1:0]          play_voice,
    output logic [PW-1:0]          play_pos
);

    logic [PW-1:0]          pos_mem [0:VOICE_COUNT-1];
    logic [PW-1:0]          pos_rd_reg;
    dvsm_pkg::step_t        s1_reg;
    logic [VW-1:0]          s1_voice_reg;
    logic [VOICE_COUNT-1:0] active_reg;
    logic [VOICE_COUNT-1:0] active_next;

    logic          hit;
    logic          live;
    logic [PW-1:0] base;
    logic [PW:0]   nxt;
    logic          stop;
    logic          play;
    logic          wr_en;
    logic [PW-1:0] wr_pos;

    always_comb
    begin
        hit    = trig_vec[s1_voice_reg];
        live   = active_reg[s1_voice_reg] | hit;
        base   = hit ? '0 : pos_rd_reg;
        nxt    = {1'b0, base} + (PW+1)'(1);
        stop   = nxt >= (PW+1)'(SAMPLE_DEPTH);
        play   = live & ~stop;
        wr_en  = s1_reg.valid & live;
        wr_pos = stop ? '0 : nxt[PW-1:0];
        active_next = active_reg;
        if (s1_reg.valid)
        begin
            active_next[s1_voice_reg] = play;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_in.valid)
        begin
            pos_rd_reg <= pos_mem[step_voice];
        end
        if (wr_en)
        begin
            pos_mem[s1_voice_reg] <= wr_pos;
        end
        s1_voice_reg <= step_voice;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg     <= '0;
            active_reg <= '0;
        end
        else
        begin
            s1_reg     <= step_in;
            active_reg <= active_next;
        end
    end

    assign play_out.valid = s1_reg.valid;
    assign play_out.last  = s1_reg.last;
    assign play_out.play  = play;
    assign play_voice     = s1_voice_reg;
    assign play_pos       = nxt[PW-1:0];

`ifndef SYNTHESIS
    // position zero is never heard
    a_no_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        play_out.valid && play_out.play |-> play_pos != '0)
        else $error("voice plays at position zero");

    a_trig_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid && hit |-> wr_en && (stop || wr_pos == PW'(1)))
        else $error("triggered voice did not restart");
`endif

endmodule

>>> hdl/drum_voice_sample_mixer.sv
// channel | signals                          | direction
// request | in_valid, in_stall, req fields   | into block
// result  | out_valid, out_stall, mix fields | out of block
//
// a load request gives no result
// a tick reads the position memory once per voice,
// then the sample-memory read and the mix add, then the output register
// new requests wait while a tick runs; a held result does not block a load
// reset clears the playing flags, no memory clearing pass
module drum_voice_sample_mixer #(
    parameter int VOICE_COUNT  = 8,
    parameter int SAMPLE_DEPTH = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [2:0]  voice_select,
    input  logic [14:0] load_address,
    input  logic [15:0] load_word,
    input  logic        fresh_poll,
    input  logic [7:0]  trigger_mask,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] mixed_sample,
    output logic [7:0]  playing_mask
);

    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int PW = $clog2(SAMPLE_DEPTH);

    dvsm_pkg::state_t       state_reg;
    dvsm_pkg::state_t       state_next;
    logic [VW-1:0]          cnt_reg;
    logic [VW-1:0]          cnt_next;
    logic [VOICE_COUNT-1:0] trig_now;
    logic [VOICE_COUNT-1:0] trig_reg;
    logic [15:0]            acc_reg;
    logic [VOICE_COUNT-1:0] mask_reg;
    logic [7:0]             mask8;
    dvsm_pkg::play_t        s2_reg;
    logic [VW-1:0]          s2_voice_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [15:0]            mixed_sample_reg;
    logic [7:0]             playing_mask_reg;

    logic                   in_fire;
    logic                   tick_start;
    logic                   load_ok;
    logic                   out_free;
    logic                   cnt_last;
    dvsm_pkg::step_t        step;
    dvsm_pkg::play_t        play_out;
    logic [VW-1:0]          play_voice;
    logic [PW-1:0]          play_pos;
    logic [15:0]            rd_data;

    assign in_stall   = state_reg != dvsm_pkg::ST_IDLE;
    assign in_fire    = in_valid & ~in_stall;
    assign tick_start = in_fire & (req_type == dvsm_pkg::REQ_TICK);
    assign load_ok    = in_fire & (req_type == dvsm_pkg::REQ_LOAD)
                      & (5'(voice_select) < 5'(VOICE_COUNT))
                      & (17'(load_address) < 17'(SAMPLE_DEPTH));
    assign out_free   = ~out_valid_reg | ~out_stall;
    assign cnt_last   = cnt_reg == VW'(VOICE_COUNT - 1);

    for (genvar g = 0; g < VOICE_COUNT; g++)
    begin : g_trig
        if (g < 8)
        begin : g_in
            assign trig_now[g] = fresh_poll & trigger_mask[g];
        end
        else
        begin : g_none
            assign trig_now[g] = 1'b0;
        end
    end

    for (genvar g = 0; g < 8; g++)
    begin : g_mask
        if (g < VOICE_COUNT)
        begin : g_in
            assign mask8[g] = mask_reg[g];
        end
        else
        begin : g_none
            assign mask8[g] = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & out_stall;
        step.valid     = 1'b0;
        step.last      = cnt_last;
        case (state_reg)
            dvsm_pkg::ST_IDLE:
            begin
                if (tick_start)
                begin
                    state_next = dvsm_pkg::ST_RUN;
                    cnt_next   = '0;
                end
            end
            dvsm_pkg::ST_RUN:
            begin
                step.valid = 1'b1;
                cnt_next   = cnt_reg + VW'(1);
                if (cnt_last)
                begin
                    state_next = dvsm_pkg::ST_DRAIN;
                end
            end
            dvsm_pkg::ST_DRAIN:
            begin
                if (s2_reg.valid && s2_reg.last)
                begin
                    state_next = dvsm_pkg::ST_DONE;
                end
            end
            dvsm_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = dvsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dvsm_pkg::ST_IDLE;
            end
        endcase
    end

    dvsm_voice_state #(
        .VOICE_COUNT  (VOICE_COUNT),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_voice (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_in    (step),
        .step_voice (cnt_reg),
        .trig_vec   (trig_reg),
        .play_out   (play_out),
        .play_voice (play_voice),
        .play_pos   (play_pos)
    );

    dvsm_sample_store #(
        .VOICE_COUNT  (VOICE_COUNT),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (load_ok),
        .wr_addr ({VW'(voice_select), PW'(load_address)}),
        .wr_data (load_word),
        .rd_en   (play_out.valid & play_out.play),
        .rd_addr ({play_voice, play_pos}),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        s2_voice_reg <= play_voice;
        if (tick_start)
        begin
            trig_reg <= trig_now;
            acc_reg  <= dvsm_pkg::MIDPOINT;
            mask_reg <= '0;
        end
        else if (s2_reg.valid && s2_reg.play)
        begin
            acc_reg                <= acc_reg + rd_data - dvsm_pkg::MIDPOINT;
            mask_reg[s2_voice_reg] <= 1'b1;
        end
        if (state_reg == dvsm_pkg::ST_DONE && out_free)
        begin
            mixed_sample_reg <= acc_reg;
            playing_mask_reg <= mask8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dvsm_pkg::ST_IDLE;
            cnt_reg       <= '0;
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            s2_reg        <= play_out;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mixed_sample = mixed_sample_reg;
    assign playing_mask = playing_mask_reg;

`ifndef SYNTHESIS
    a_s2_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        s2_reg.valid |-> state_reg == dvsm_pkg::ST_RUN || state_reg == dvsm_pkg::ST_DRAIN)
        else $error("mix stage busy outside a tick");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == dvsm_pkg::ST_DONE))
        else $error("result raised outside done state");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dvsm_pkg::ST_IDLE |-> !s2_reg.valid && !play_out.valid)
        else $error("pipeline not empty while idle");
`endif

endmodule

>>> dv/drum_voice_sample_mixer_test.sv
module drum_voice_sample_mixer_test;

    localparam int VOICES = 8;
    localparam int DEPTH  = 32768;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  voice_select;
        logic [14:0] load_address;
        logic [15:0] load_word;
        logic        fresh_poll;
        logic [7:0]  trigger_mask;
        logic        makes_mix;
        logic [15:0] mix_value;
        logic [7:0]  mix_mask;
        logic        hold_for_drain;
        logic        brisk;
    } mixer_request_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        req_type     = dvsm_pkg::REQ_LOAD;
    logic [2:0]  voice_select = '0;
    logic [14:0] load_address = '0;
    logic [15:0] load_word    = '0;
    logic        fresh_poll   = 1'b0;
    logic [7:0]  trigger_mask = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [15:0] mixed_sample;
    logic [7:0]  playing_mask;

    mixer_request_t pending_requests[$];
    mixer_request_t mix_expected[$];
    mixer_request_t on_wire;
    mixer_request_t mix_head;
    bit             sending        = 1'b0;
    int unsigned    send_gap       = 0;
    int unsigned    stall_left     = 0;
    logic           hold_off       = 1'b0;
    int unsigned    mismatch_count = 0;
    int unsigned    results_seen   = 0;

    // shadow of the voice engine
    logic [15:0]      sample_copy [0:VOICES*DEPTH-1];
    bit               sample_written [0:VOICES*DEPTH-1];
    logic [7:0]       voice_on  = '0;
    logic [7:0][15:0] voice_pos = '0;

    drum_voice_sample_mixer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .voice_select (voice_select),
        .load_address (load_address),
        .load_word    (load_word),
        .fresh_poll   (fresh_poll),
        .trigger_mask (trigger_mask),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mixed_sample (mixed_sample),
        .playing_mask (playing_mask)
    );

    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        if (roll < 98)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic void advance_voices(input logic fresh, input logic [7:0] trig,
                                           output logic [7:0] on_next,
                                           output logic [7:0][15:0] pos_next);
        on_next  = voice_on;
        pos_next = voice_pos;
        for (int i = 0; i < VOICES; i++)
        begin
            if (fresh && trig[i])
            begin
                on_next[i]  = 1'b1;
                pos_next[i] = '0;
            end
            if (on_next[i])
            begin
                if (int'(pos_next[i]) + 1 >= DEPTH)
                begin
                    on_next[i]  = 1'b0;
                    pos_next[i] = '0;
                end
                else
                    pos_next[i] = pos_next[i] + 16'd1;
            end
        end
    endfunction

    task automatic enqueue_request(input mixer_request_t rq);
        logic [7:0]       on_next;
        logic [7:0][15:0] pos_next;
        logic [15:0]      mix;
        if (rq.req_type == dvsm_pkg::REQ_LOAD)
        begin
            sample_copy[{rq.voice_select, rq.load_address}]    = rq.load_word;
            sample_written[{rq.voice_select, rq.load_address}] = 1'b1;
            rq.makes_mix = 1'b0;
        end
        else
        begin
            advance_voices(rq.fresh_poll, rq.trigger_mask, on_next, pos_next);
            voice_on  = on_next;
            voice_pos = pos_next;
            mix = dvsm_pkg::MIDPOINT;
            for (int i = 0; i < VOICES; i++)
                if (voice_on[i])
                    mix = mix + sample_copy[{3'(i), voice_pos[i][14:0]}]
                          - dvsm_pkg::MIDPOINT;
            rq.makes_mix = 1'b1;
            rq.mix_value = mix;
            rq.mix_mask  = voice_on;
        end
        pending_requests.push_back(rq);
    endtask

    task automatic plan_load(input logic [2:0] voice, input logic [14:0] addr,
                             input logic [15:0] word);
        mixer_request_t rq;
        rq = '0;
        rq.req_type     = dvsm_pkg::REQ_LOAD;
        rq.voice_select = voice;
        rq.load_address = addr;
        rq.load_word    = word;
        enqueue_request(rq);
    endtask

    // writes any unwritten sample word the tick is about to read, then the tick itself
    task automatic plan_tick(input logic fresh, input logic [7:0] trig,
                             input logic hold, input logic brisk);
        mixer_request_t   rq;
        logic [7:0]       on_next;
        logic [7:0][15:0] pos_next;
        logic             hold_left;
        hold_left = hold;
        advance_voices(fresh, trig, on_next, pos_next);
        for (int i = 0; i < VOICES; i++)
        begin
            if (on_next[i] && !sample_written[{3'(i), pos_next[i][14:0]}])
            begin
                rq = '0;
                rq.req_type       = dvsm_pkg::REQ_LOAD;
                rq.voice_select   = 3'(i);
                rq.load_address   = pos_next[i][14:0];
                rq.load_word      = 16'($urandom);
                rq.hold_for_drain = hold_left;
                rq.brisk          = brisk;
                hold_left = 1'b0;
                enqueue_request(rq);
            end
        end
        rq = '0;
        rq.req_type       = dvsm_pkg::REQ_TICK;
        rq.fresh_poll     = fresh;
        rq.trigger_mask   = trig;
        rq.voice_select   = 3'($urandom);
        rq.load_address   = 15'($urandom);
        rq.load_word      = 16'($urandom);
        rq.hold_for_drain = hold_left;
        rq.brisk          = brisk;
        enqueue_request(rq);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] seen,
                                   input logic [15:0] wanted);
        if (mismatch_count < 100)
            $display("%0t mismatch on %s: got %h, want %h", $time, what, seen, wanted);
        mismatch_count++;
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sending = 1'b0;
            send_gap = 0;
            in_valid <= 1'b0;
        end
        else
        begin
            if (sending && !in_stall)
            begin
                if (on_wire.makes_mix)
                    mix_expected.push_back(on_wire);
                sending = 1'b0;
                send_gap = (on_wire.brisk && $urandom_range(31) != 0) ? 0 : idle_len();
            end
            if (!sending)
            begin
                if (send_gap != 0)
                    send_gap--;
                else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].hold_for_drain && mix_expected.size() != 0))
                begin
                    on_wire = pending_requests.pop_front();
                    sending = 1'b1;
                    req_type     <= on_wire.req_type;
                    voice_select <= on_wire.voice_select;
                    load_address <= on_wire.load_address;
                    load_word    <= on_wire.load_word;
                    fresh_poll   <= on_wire.fresh_poll;
                    trigger_mask <= on_wire.trigger_mask;
                end
            end
            in_valid <= sending;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (mix_expected.size() == 0)
                report_mismatch("result with no tick waiting", mixed_sample, 16'h0);
            else
            begin
                mix_head = mix_expected.pop_front();
                if (mixed_sample !== mix_head.mix_value)
                    report_mismatch("mixed_sample", mixed_sample, mix_head.mix_value);
                if (playing_mask !== mix_head.mix_mask)
                    report_mismatch("playing_mask", {8'h0, playing_mask},
                                    {8'h0, mix_head.mix_mask});
            end
        end
        if (stall_left != 0)
            stall_left--;
        else
            stall_left = idle_len();
        out_stall <= hold_off || stall_left != 0;
    end

    // long receiver hold so the block backs up
    initial
    begin
        wait (results_seen >= 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #(600_000_000);
        $display("drum_voice_sample_mixer_test failed");
        $finish;
    end

    initial
    begin
        int unsigned base;
        int unsigned roll;
        logic [7:0]  trig;

        plan_load(3'd0, 15'd1, 16'h0000);
        plan_load(3'd7, 15'd32767, 16'hFFFF);
        plan_load(3'd7, 15'd0, 16'h8000);
        plan_load(3'd4, 15'h4000, 16'h7FFF);
        // stale trigger: nothing starts
        plan_tick(1'b0, 8'hFF, 1'b0, 1'b0);
        plan_tick(1'b1, 8'h01, 1'b0, 1'b0);
        for (int v = 0; v < VOICES; v++)
            plan_load(3'(v), 15'd1, 16'hFFFF);
        // all voices at full scale, sum wraps
        plan_tick(1'b1, 8'hFF, 1'b0, 1'b0);
        // restart one voice while the rest play on
        plan_tick(1'b1, 8'h04, 1'b0, 1'b0);

        base = pending_requests.size();
        while (pending_requests.size() - base < 1950)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                plan_load(3'($urandom_range(7)),
                          15'(roll < 24 ? $urandom_range(63) : $urandom_range(32767)),
                          16'($urandom));
            else
            begin
                if (roll < 34)
                    trig = 8'hFF;
                else if (roll < 37)
                    trig = 8'h00;
                else
                    trig = 8'($urandom);
                plan_tick(1'($urandom_range(1)), trig, $urandom_range(99) == 0, 1'b0);
            end
        end

        // sender waits for every result before this tick or the first sample load it plans
        plan_tick(1'b1, 8'h20 | (8'($urandom) & 8'hDF), 1'b1, 1'b1);
        plan_tick(1'b1, 8'h20, 1'b0, 1'b0);
        plan_tick(1'b0, 8'h00, 1'b0, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_requests.size() != 0 || sending || mix_expected.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("drum_voice_sample_mixer_test passed");
        else
            $display("drum_voice_sample_mixer_test failed");
        $finish;
    end

endmodule

>>> files.f
hdl/dvsm_pkg.sv
hdl/dvsm_sample_store.sv
hdl/dvsm_voice_state.sv
hdl/drum_voice_sample_mixer.sv
dv/drum_voice_sample_mixer_test.sv
